// ===== design/dmbp_pkg.sv =====
// ----------------------------------------------------------------------------
// dmbp_pkg
// Shared types and constants for the DNS message body parser.
// ----------------------------------------------------------------------------
package dmbp_pkg;

    localparam int unsigned LABEL_MAX      = 63;
    localparam int unsigned NAME_MAX       = 255;
    localparam logic [15:0] RDATA_LIMIT_RST = 16'd1024;
    localparam logic [7:0]  CHAR_DOT       = 8'h2e;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [3:0] KIND_NAME_CHAR = 4'd0;
    localparam logic [3:0] KIND_NAME_END  = 4'd1;
    localparam logic [3:0] KIND_TYPE      = 4'd2;
    localparam logic [3:0] KIND_CLASS     = 4'd3;
    localparam logic [3:0] KIND_TTL       = 4'd4;
    localparam logic [3:0] KIND_RDLENGTH  = 4'd5;
    localparam logic [3:0] KIND_RDATA     = 4'd6;
    localparam logic [3:0] KIND_MSG_OK    = 4'd7;
    localparam logic [3:0] KIND_ERROR     = 4'd8;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_LABEL_LONG = 3'd1;
    localparam logic [2:0] ERR_NAME_LONG  = 3'd2;
    localparam logic [2:0] ERR_RDATA_LONG = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd4;
    localparam logic [2:0] ERR_TRAILING   = 3'd5;

    localparam logic [1:0] SEC_ADDITIONAL = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  section;
        logic [15:0] record_index;
        logic [31:0] field_value;
        logic [2:0]  err_code;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res1;
        t_result    res0;
    } t_push;

    function automatic t_result make_result(input logic [3:0]  kind,
                                            input logic [1:0]  section,
                                            input logic [15:0] record_index,
                                            input logic [31:0] field_value,
                                            input logic [2:0]  err_code);
        t_result r;
        r.kind         = kind;
        r.section      = (kind < KIND_MSG_OK) ? section : 2'd0;
        r.record_index = (kind < KIND_MSG_OK) ? record_index : 16'd0;
        r.field_value  = field_value;
        r.err_code     = err_code;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

// ===== design/dns_message_body_parser_core.sv =====
// ----------------------------------------------------------------------------
// dns_message_body_parser_core
// Parses a DNS message body after the header into name, field and status
// results.
// ----------------------------------------------------------------------------
// The slave stream takes one word per cycle: tuser holds the opcode (start,
// body byte, end), tdata the body byte and the four header section counts.
// Every word is decoded in the cycle it is accepted, and its zero, one or
// two results are registered in a four-entry result queue before they
// appear on the master stream. tlast marks the final result of a word.
// s_axis_tready is high while the queue has room for two results, so one
// word per cycle is sustained as long as the words produce on average at
// most one result each; the last byte of a name label produces two, the
// byte and a dot, which the master stream hands out one at a time. When the
// receiver stalls, results wait in the queue and input is held off once it
// is nearly full. The rdata length limit is written through the cfg channel,
// which is always ready. Reset empties the queue, returns the parser to idle
// and sets the limit to 1024 bytes.
// ----------------------------------------------------------------------------
module dns_message_body_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte, question_count, answer_count, authority_count, additional_count
    input  logic [71:0] s_axis_tdata,
    // opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // section, record_index, field_value, err_code, zero fill
    output logic [55:0] m_axis_tdata,
    // kind
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import dmbp_pkg::*;

    logic [15:0] r_rdata_limit;
    logic        room;
    logic        accept;
    t_push       push;
    t_result     head;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdata_limit <= RDATA_LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_rdata_limit <= i_cfg_data;
        end
    end

    dmbp_parser u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (accept),
        .i_opcode           (s_axis_tuser),
        .i_data_byte        (s_axis_tdata[7:0]),
        .i_question_count   (s_axis_tdata[23:8]),
        .i_answer_count     (s_axis_tdata[39:24]),
        .i_authority_count  (s_axis_tdata[55:40]),
        .i_additional_count (s_axis_tdata[71:56]),
        .i_rdata_limit      (r_rdata_limit),
        .o_push             (push)
    );

    dmbp_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .o_head  (head)
    );

    assign m_axis_tdata = {3'd0, head.err_code, head.field_value,
                           head.record_index, head.section};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_run;

endmodule

// ===== design/dmbp_parser.sv =====
// ----------------------------------------------------------------------------
// dmbp_parser
// Parse state of the message body; turns one accepted word into up to two
// results in the same cycle.
// ----------------------------------------------------------------------------
module dmbp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_data_byte,
    input  logic [15:0]       i_question_count,
    input  logic [15:0]       i_answer_count,
    input  logic [15:0]       i_authority_count,
    input  logic [15:0]       i_additional_count,
    input  logic [15:0]       i_rdata_limit,
    output dmbp_pkg::t_push   o_push
);
    import dmbp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_LEN, PH_LABEL, PH_TYPE, PH_CLASS,
        PH_TTL, PH_RDLEN, PH_RDATA, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_section, n_section;
    logic [15:0] r_left [4];
    logic [15:0] n_left [4];
    logic [15:0] r_counter, n_counter;
    logic [5:0]  r_label_left, n_label_left;
    logic [8:0]  r_name_sum, n_name_sum;
    logic [31:0] r_shift, n_shift;
    logic [1:0]  r_byte_cnt, n_byte_cnt;
    logic [15:0] r_rdata_left, n_rdata_left;

    logic        rec_done;
    logic        found;
    logic        emit_ok;
    logic        field_last;
    logic [9:0]  name_next;
    logic [31:0] shifted;
    logic [15:0] rdata_next;
    logic [5:0]  label_next;
    t_push       push;

    assign emit_ok    = (r_section != SEC_ADDITIONAL);
    assign shifted    = {r_shift[23:0], i_data_byte};
    assign field_last = (r_phase == PH_TTL) ? (r_byte_cnt == 2'd3) : (r_byte_cnt != 2'd0);
    assign name_next  = {1'b0, r_name_sum} + {2'b00, i_data_byte};
    assign rdata_next = r_rdata_left - 16'd1;
    assign label_next = r_label_left - 6'd1;

    always_comb begin
        n_phase      = r_phase;
        n_section    = r_section;
        n_left       = r_left;
        n_counter    = r_counter;
        n_label_left = r_label_left;
        n_name_sum   = r_name_sum;
        n_shift      = r_shift;
        n_byte_cnt   = r_byte_cnt;
        n_rdata_left = r_rdata_left;
        rec_done     = 1'b0;
        found        = 1'b0;
        push         = '0;

        if (i_valid) begin
            if (i_opcode == OP_START) begin
                n_left[0]    = i_question_count;
                n_left[1]    = i_answer_count;
                n_left[2]    = i_authority_count;
                n_left[3]    = i_additional_count;
                n_section    = 2'd0;
                n_counter    = 16'd0;
                n_shift      = 32'd0;
                n_byte_cnt   = 2'd0;
                n_rdata_left = 16'd0;
                for (int s = 0; s < 4; s++) begin
                    if (!found && n_left[s] != 16'd0) begin
                        found        = 1'b1;
                        n_section    = 2'(s);
                        n_phase      = PH_LEN;
                        n_name_sum   = 9'd0;
                        n_label_left = 6'd0;
                    end
                end
                if (!found) begin
                    n_phase = PH_DONE;
                end
            end else if (r_phase != PH_IDLE && i_opcode != OP_RSVD) begin
                if (i_opcode == OP_BYTE) begin
                    unique case (r_phase)
                        PH_LEN: begin
                            if (i_data_byte > 8'(LABEL_MAX)) begin
                                n_phase    = PH_IDLE;
                                push.count = 2'd1;
                                push.res0  = make_result(KIND_ERROR, r_section, r_counter,
                                                         32'd0, ERR_LABEL_LONG);
                            end else if (i_data_byte == 8'd0) begin
                                push.count = emit_ok ? 2'd1 : 2'd0;
                                push.res0  = make_result(KIND_NAME_END, r_section, r_counter,
                                                         {23'd0, r_name_sum}, ERR_NONE);
                                n_phase    = PH_TYPE;
                                n_shift    = 32'd0;
                                n_byte_cnt = 2'd0;
                            end else if (name_next > 10'(NAME_MAX)) begin
                                n_phase    = PH_IDLE;
                                push.count = 2'd1;
                                push.res0  = make_result(KIND_ERROR, r_section, r_counter,
                                                         32'd0, ERR_NAME_LONG);
                            end else begin
                                n_name_sum   = name_next[8:0];
                                n_label_left = i_data_byte[5:0];
                                n_phase      = PH_LABEL;
                            end
                        end
                        PH_LABEL: begin
                            push.res0    = make_result(KIND_NAME_CHAR, r_section, r_counter,
                                                       {24'd0, i_data_byte}, ERR_NONE);
                            push.res1    = make_result(KIND_NAME_CHAR, r_section, r_counter,
                                                       {24'd0, CHAR_DOT}, ERR_NONE);
                            n_label_left = label_next;
                            if (label_next == 6'd0) begin
                                push.count = emit_ok ? 2'd2 : 2'd0;
                                n_phase    = PH_LEN;
                            end else begin
                                push.count = emit_ok ? 2'd1 : 2'd0;
                            end
                        end
                        PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN: begin
                            n_shift = shifted;
                            if (!field_last) begin
                                n_byte_cnt = r_byte_cnt + 2'd1;
                            end else begin
                                unique case (r_phase)
                                    PH_TYPE: begin
                                        push.count = emit_ok ? 2'd1 : 2'd0;
                                        push.res0  = make_result(KIND_TYPE, r_section,
                                                                 r_counter,
                                                                 {16'd0, shifted[15:0]},
                                                                 ERR_NONE);
                                        n_phase    = PH_CLASS;
                                        n_shift    = 32'd0;
                                        n_byte_cnt = 2'd0;
                                    end
                                    PH_CLASS: begin
                                        push.count = emit_ok ? 2'd1 : 2'd0;
                                        push.res0  = make_result(KIND_CLASS, r_section,
                                                                 r_counter,
                                                                 {16'd0, shifted[15:0]},
                                                                 ERR_NONE);
                                        if (r_section == 2'd0) begin
                                            rec_done = 1'b1;
                                        end else begin
                                            n_phase    = PH_TTL;
                                            n_shift    = 32'd0;
                                            n_byte_cnt = 2'd0;
                                        end
                                    end
                                    PH_TTL: begin
                                        push.count = emit_ok ? 2'd1 : 2'd0;
                                        push.res0  = make_result(KIND_TTL, r_section,
                                                                 r_counter, shifted,
                                                                 ERR_NONE);
                                        n_phase    = PH_RDLEN;
                                        n_shift    = 32'd0;
                                        n_byte_cnt = 2'd0;
                                    end
                                    default: begin
                                        if (shifted[15:0] > i_rdata_limit) begin
                                            n_phase    = PH_IDLE;
                                            push.count = 2'd1;
                                            push.res0  = make_result(KIND_ERROR, r_section,
                                                                     r_counter, 32'd0,
                                                                     ERR_RDATA_LONG);
                                        end else begin
                                            push.count = emit_ok ? 2'd1 : 2'd0;
                                            push.res0  = make_result(KIND_RDLENGTH,
                                                                     r_section, r_counter,
                                                                     {16'd0, shifted[15:0]},
                                                                     ERR_NONE);
                                            if (shifted[15:0] == 16'd0) begin
                                                rec_done = 1'b1;
                                            end else begin
                                                n_rdata_left = shifted[15:0];
                                                n_phase      = PH_RDATA;
                                            end
                                        end
                                    end
                                endcase
                            end
                        end
                        PH_RDATA: begin
                            push.count   = emit_ok ? 2'd1 : 2'd0;
                            push.res0    = make_result(KIND_RDATA, r_section, r_counter,
                                                       {24'd0, i_data_byte}, ERR_NONE);
                            n_rdata_left = rdata_next;
                            if (rdata_next == 16'd0) begin
                                rec_done = 1'b1;
                            end
                        end
                        PH_DONE: begin
                            n_phase    = PH_IDLE;
                            push.count = 2'd1;
                            push.res0  = make_result(KIND_ERROR, r_section, r_counter,
                                                     32'd0, ERR_TRAILING);
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end else begin
                    n_phase    = PH_IDLE;
                    push.count = 2'd1;
                    if (r_phase == PH_DONE) begin
                        push.res0 = make_result(KIND_MSG_OK, r_section, r_counter,
                                                32'd0, ERR_NONE);
                    end else begin
                        push.res0 = make_result(KIND_ERROR, r_section, r_counter,
                                                32'd0, ERR_TRUNCATED);
                    end
                end
            end
        end

        if (rec_done) begin
            n_left[r_section] = r_left[r_section] - 16'd1;
            n_counter         = r_counter + 16'd1;
            if (n_left[r_section] != 16'd0) begin
                n_phase      = PH_LEN;
                n_name_sum   = 9'd0;
                n_label_left = 6'd0;
            end else begin
                for (int s = 0; s < 4; s++) begin
                    if (!found && s > int'(r_section) && n_left[s] != 16'd0) begin
                        found        = 1'b1;
                        n_section    = 2'(s);
                        n_counter    = 16'd0;
                        n_phase      = PH_LEN;
                        n_name_sum   = 9'd0;
                        n_label_left = 6'd0;
                    end
                end
                if (!found) begin
                    n_phase = PH_DONE;
                end
            end
        end

        if (push.count == 2'd1) begin
            push.res0.last_of_run = 1'b1;
        end
        if (push.count == 2'd2) begin
            push.res1.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_section    <= 2'd0;
            r_left       <= '{default: 16'd0};
            r_counter    <= 16'd0;
            r_label_left <= 6'd0;
            r_name_sum   <= 9'd0;
            r_shift      <= 32'd0;
            r_byte_cnt   <= 2'd0;
            r_rdata_left <= 16'd0;
        end else begin
            r_phase      <= n_phase;
            r_section    <= n_section;
            r_left       <= n_left;
            r_counter    <= n_counter;
            r_label_left <= n_label_left;
            r_name_sum   <= n_name_sum;
            r_shift      <= n_shift;
            r_byte_cnt   <= n_byte_cnt;
            r_rdata_left <= n_rdata_left;
        end
    end

    assign o_push = push;

endmodule

// ===== design/dmbp_out_queue.sv =====
// ----------------------------------------------------------------------------
// dmbp_out_queue
// Four-entry result queue that takes up to two results per cycle and hands
// out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module dmbp_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dmbp_pkg::t_push     i_push,
    input  logic                i_pop,
    output logic                o_room,
    output logic                o_valid,
    output dmbp_pkg::t_result   o_head
);
    import dmbp_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       pop;
    logic [1:0] wr_ptr_1;

    assign pop      = i_pop && (r_count != 3'd0);
    assign wr_ptr_1 = r_wr_ptr + 2'd1;
    assign n_wr_ptr = r_wr_ptr + i_push.count;
    assign n_rd_ptr = pop ? r_rd_ptr + 2'd1 : r_rd_ptr;
    assign n_count  = r_count + {1'b0, i_push.count} - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.res1;
        end
    end

    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DNS message body parser core. Plain tasks feed
// start, body byte, end and reserved words on the input stream and write
// the rdata length limit between phases. A scoreboard class parses every
// accepted word alone and checks each output word, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import dmbp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [1:0] SEC_QUESTION = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LEN, ST_LABEL, ST_TYPE, ST_CLASS, ST_TTL, ST_RDLEN, ST_RDATA, ST_DONE
    } t_parse_state;

    typedef struct {
        logic [1:0]  op;
        logic [71:0] data;
    } t_body_word;

    class dns_parse_scoreboard;
        t_parse_state state;
        logic [1:0]   sec;
        logic [15:0]  records_left [4];
        logic [15:0]  record_idx;
        logic [5:0]   label_left;
        logic [8:0]   name_sum;
        logic [31:0]  field_acc;
        logic [1:0]   field_bytes;
        logic [15:0]  rdata_left;
        logic [15:0]  rdata_limit;
        t_result      pending_fields[$];
        t_result      word_fields[$];
        int           mismatches;

        function new();
            state = ST_IDLE;
            sec = SEC_QUESTION;
            foreach (records_left[i]) records_left[i] = '0;
            record_idx = '0;
            label_left = '0;
            name_sum = '0;
            field_acc = '0;
            field_bytes = '0;
            rdata_left = '0;
            rdata_limit = RDATA_LIMIT_RST;
            mismatches = 0;
        endfunction

        function void push(logic [3:0] kind, logic [31:0] val, logic [2:0] err);
            t_result r;
            r.kind = kind;
            r.section = (kind < KIND_MSG_OK) ? sec : 2'd0;
            r.record_index = (kind < KIND_MSG_OK) ? record_idx : 16'd0;
            r.field_value = val;
            r.err_code = err;
            r.last_of_run = 1'b0;
            word_fields.insert(word_fields.size(), r);
        endfunction

        // Additional records are parsed but stay silent.
        function void emit(logic [3:0] kind, logic [31:0] val);
            if (sec != SEC_ADDITIONAL) begin
                push(kind, val, ERR_NONE);
            end
        endfunction

        function void fail(logic [2:0] code);
            state = ST_IDLE;
            push(KIND_ERROR, 32'd0, code);
        endfunction

        function void begin_name();
            state = ST_LEN;
            name_sum = '0;
            label_left = '0;
        endfunction

        function void seek_section(int from);
            for (int s = from; s < 4; s++) begin
                if (records_left[s] != 16'd0) begin
                    sec = 2'(s);
                    record_idx = '0;
                    begin_name();
                    return;
                end
            end
            state = ST_DONE;
        endfunction

        function void record_done();
            records_left[sec] = records_left[sec] - 16'd1;
            record_idx = record_idx + 16'd1;
            if (records_left[sec] != 16'd0) begin
                begin_name();
            end else begin
                seek_section(int'(sec) + 1);
            end
        endfunction

        function void next_field(t_parse_state st);
            state = st;
            field_acc = '0;
            field_bytes = '0;
        endfunction

        function void take_byte(logic [7:0] b);
            int need;
            logic [15:0] len;
            case (state)
                ST_LEN: begin
                    if (b > 8'(LABEL_MAX)) begin
                        fail(ERR_LABEL_LONG);
                    end else if (b == 8'd0) begin
                        emit(KIND_NAME_END, {23'd0, name_sum});
                        next_field(ST_TYPE);
                    end else if (int'(name_sum) + int'(b) > int'(NAME_MAX)) begin
                        fail(ERR_NAME_LONG);
                    end else begin
                        name_sum = name_sum + 9'(b);
                        label_left = b[5:0];
                        state = ST_LABEL;
                    end
                end
                ST_LABEL: begin
                    emit(KIND_NAME_CHAR, {24'd0, b});
                    label_left = label_left - 6'd1;
                    if (label_left == 6'd0) begin
                        emit(KIND_NAME_CHAR, {24'd0, CHAR_DOT});
                        state = ST_LEN;
                    end
                end
                ST_TYPE, ST_CLASS, ST_TTL, ST_RDLEN: begin
                    need = (state == ST_TTL) ? 4 : 2;
                    field_acc = {field_acc[23:0], b};
                    if (int'(field_bytes) + 1 < need) begin
                        field_bytes = field_bytes + 2'd1;
                    end else begin
                        case (state)
                            ST_TYPE: begin
                                emit(KIND_TYPE, {16'd0, field_acc[15:0]});
                                next_field(ST_CLASS);
                            end
                            ST_CLASS: begin
                                emit(KIND_CLASS, {16'd0, field_acc[15:0]});
                                if (sec == SEC_QUESTION) begin
                                    record_done();
                                end else begin
                                    next_field(ST_TTL);
                                end
                            end
                            ST_TTL: begin
                                emit(KIND_TTL, field_acc);
                                next_field(ST_RDLEN);
                            end
                            default: begin
                                len = field_acc[15:0];
                                if (len > rdata_limit) begin
                                    fail(ERR_RDATA_LONG);
                                end else begin
                                    emit(KIND_RDLENGTH, {16'd0, len});
                                    if (len == 16'd0) begin
                                        record_done();
                                    end else begin
                                        rdata_left = len;
                                        state = ST_RDATA;
                                    end
                                end
                            end
                        endcase
                    end
                end
                ST_RDATA: begin
                    emit(KIND_RDATA, {24'd0, b});
                    rdata_left = rdata_left - 16'd1;
                    if (rdata_left == 16'd0) begin
                        record_done();
                    end
                end
                ST_DONE: begin
                    fail(ERR_TRAILING);
                end
                default: begin
                end
            endcase
        endfunction

        function void note_word(logic [1:0] op, logic [71:0] data);
            word_fields.delete();
            if (op == OP_START) begin
                records_left[0] = data[23:8];
                records_left[1] = data[39:24];
                records_left[2] = data[55:40];
                records_left[3] = data[71:56];
                sec = SEC_QUESTION;
                record_idx = '0;
                field_acc = '0;
                field_bytes = '0;
                rdata_left = '0;
                seek_section(0);
            end else if (state != ST_IDLE && op != OP_RSVD) begin
                if (op == OP_BYTE) begin
                    take_byte(data[7:0]);
                end else if (state == ST_DONE) begin
                    state = ST_IDLE;
                    push(KIND_MSG_OK, 32'd0, ERR_NONE);
                end else begin
                    fail(ERR_TRUNCATED);
                end
            end
            if (word_fields.size() > 0) begin
                word_fields[word_fields.size() - 1].last_of_run = 1'b1;
            end
            foreach (word_fields[i]) pending_fields.insert(pending_fields.size(), word_fields[i]);
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task check_field(t_result got);
            t_result want;
            if (pending_fields.size() == 0) begin
                report($sformatf("unexpected word kind %0d value %0h", got.kind,
                                 got.field_value));
                return;
            end
            want = pending_fields[0];
            pending_fields.delete(0);
            if (got.kind != want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.section != want.section)
                report($sformatf("section %0d, expected %0d", got.section, want.section));
            if (got.record_index != want.record_index)
                report($sformatf("record index %0d, expected %0d", got.record_index,
                                 want.record_index));
            if (got.field_value != want.field_value)
                report($sformatf("value %0h, expected %0h (kind %0d)", got.field_value,
                                 want.field_value, want.kind));
            if (got.err_code != want.err_code)
                report($sformatf("error code %0d, expected %0d", got.err_code,
                                 want.err_code));
            if (got.last_of_run != want.last_of_run)
                report($sformatf("tlast %0d, expected %0d", got.last_of_run,
                                 want.last_of_run));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_RSVD;
    logic        m_ready = 1'b0;

    wire         cfg_ready;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [55:0] m_axis_tdata;
    wire  [3:0]  m_axis_tuser;
    wire         m_axis_tlast;

    dns_parse_scoreboard sb;
    t_body_word  msg_words[$];
    int unsigned cur_limit = RDATA_LIMIT_RST;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          stall_requests = 0;
    int          stalls_done = 0;
    int          stall_left = 0;
    int          cycles = 0;

    dns_message_body_parser_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL dns_message_body_parser_core");
            $finish;
        end
    end

    // Output side: check accepted words, then pick the next ready value.
    always @(posedge clk) begin : rx_side
        t_result got;
        if (rst_n && m_axis_tvalid && m_ready) begin
            got.kind = m_axis_tuser;
            got.section = m_axis_tdata[1:0];
            got.record_index = m_axis_tdata[17:2];
            got.field_value = m_axis_tdata[49:18];
            got.err_code = m_axis_tdata[52:50];
            got.last_of_run = m_axis_tlast;
            sb.check_field(got);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (stalls_done != stall_requests) begin
            stalls_done = stalls_done + 1;
            stall_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(rx_idle_on && $urandom_range(0, 99) < 33);
        end
    end

    function automatic void put_word(logic [1:0] op, logic [71:0] data);
        t_body_word w;
        w.op = op;
        w.data = data;
        msg_words.insert(msg_words.size(), w);
    endfunction

    function automatic void put_byte(logic [7:0] b);
        put_word(OP_BYTE, {$urandom(), $urandom(), b});
    endfunction

    function automatic void put_op(logic [1:0] op);
        put_word(op, {$urandom(), $urandom(), 8'($urandom())});
    endfunction

    function automatic void put_start(logic [15:0] q, logic [15:0] an, logic [15:0] au,
                                      logic [15:0] ad);
        put_word(OP_START, {ad, au, an, q, 8'($urandom())});
    endfunction

    function automatic void put_field(logic [31:0] v, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) put_byte(v[8*i +: 8]);
    endfunction

    function automatic void put_label(int len);
        put_byte(8'(len));
        repeat (len) put_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_name(int nlabels);
        repeat (nlabels) put_label($urandom_range(1, 8));
        put_byte(8'd0);
    endfunction

    function automatic void put_record(bit question);
        int unsigned len;
        put_name($urandom_range(0, 3));
        put_field($urandom(), 2);
        put_field($urandom(), 2);
        if (!question) begin
            put_field($urandom(), 4);
            len = $urandom_range(0, (cur_limit < 6) ? cur_limit : 6);
            put_field(len, 2);
            repeat (len) put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void put_message(int q, int an, int au, int ad);
        put_start(16'(q), 16'(an), 16'(au), 16'(ad));
        repeat (q) put_record(1'b1);
        repeat (an + au + ad) put_record(1'b0);
    endfunction

    // Four full labels, then a last label that lands exactly on the name
    // limit or crosses it.
    function automatic void put_long_name(bit over);
        put_start(16'd1, 16'd0, 16'd0, 16'd0);
        repeat (4) put_label(LABEL_MAX);
        if (over) begin
            put_byte(8'($urandom_range(4, LABEL_MAX)));
        end else begin
            put_label(3);
            put_byte(8'd0);
            put_field($urandom(), 2);
            put_field($urandom(), 2);
        end
        put_op(OP_END);
    endfunction

    // Queues one message of a random shape; returns how many words count as
    // real work.
    function automatic int queue_message();
        int pick;
        int mark;
        int cut;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            put_message($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 2),
                        $urandom_range(0, 2));
            put_op(OP_END);
        end else if (pick < 62) begin
            put_message($urandom_range(1, 2), $urandom_range(0, 2), $urandom_range(0, 1),
                        $urandom_range(0, 1));
            mark = msg_words.size();
            put_op(OP_END);
            cut = $urandom_range(msg_words.size() - mark, msg_words.size() - 1);
            while (msg_words.size() > cut) void'(msg_words.pop_back());
            put_op(OP_END);
        end else if (pick < 68) begin
            put_message($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 1));
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
            put_op(OP_END);
        end else if (pick < 74) begin
            put_start(16'd1, 16'($urandom_range(0, 1)), 16'd0, 16'd0);
            if ($urandom_range(0, 1)) put_label($urandom_range(1, 5));
            put_byte(8'($urandom_range(LABEL_MAX + 1, 255)));
            put_byte(8'($urandom_range(0, 255)));
            put_op(OP_END);
        end else if (pick < 80 && cur_limit < 65535) begin
            put_start(16'd0, 16'd0, 16'($urandom_range(0, 1)), 16'($urandom_range(1, 2)));
            put_name($urandom_range(0, 2));
            put_field($urandom(), 2);
            put_field($urandom(), 2);
            put_field($urandom(), 4);
            put_field($urandom_range(cur_limit + 1, 65535), 2);
            put_op(OP_END);
        end else if (pick < 86) begin
            put_start(16'($urandom_range(1, 3)), 16'd1, 16'd0, 16'd0);
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(1, 4)));
            put_message($urandom_range(0, 2), $urandom_range(0, 2), 0, $urandom_range(0, 1));
            put_op(OP_END);
        end else if (pick < 92) begin
            put_op(OP_RSVD);
            put_byte(8'($urandom_range(0, 255)));
            put_op(OP_END);
            return 0;
        end else begin
            put_start(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) put_op(OP_RSVD);
            put_op(OP_END);
        end
        return msg_words.size();
    endfunction

    task automatic send_word(t_body_word w);
        while (tx_idle_on && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w.data;
        s_tuser <= w.op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_word(w.op, w.data);
    endtask

    task automatic send_queued();
        foreach (msg_words[i]) send_word(msg_words[i]);
        msg_words.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_fields.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.rdata_limit = v;
        cur_limit = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [15:0] limit, bit tx_on, bit rx_on, bit hold,
                             bit long_names, int target);
        int sent;
        sent = 0;
        drain();
        write_limit(limit);
        tx_idle_on = tx_on;
        rx_idle_on = rx_on;
        if (hold) stall_requests++;
        if (long_names) begin
            put_long_name(1'b0);
            put_long_name(1'b1);
            sent = msg_words.size();
            send_queued();
        end
        while (sent < target) begin
            sent += queue_message();
            send_queued();
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One question with a single 0xff label, extreme type and class.
        put_start(16'd1, 16'd0, 16'd0, 16'd0);
        put_byte(8'd1);
        put_byte(8'hff);
        put_byte(8'd0);
        put_field(32'h0000ffff, 2);
        put_field(32'h0, 2);
        put_op(OP_END);
        // Byte after an empty message, then words that must be ignored and a second empty message.
        put_start(16'd0, 16'd0, 16'd0, 16'd0);
        put_byte(8'd0);
        put_op(OP_END);
        put_op(OP_RSVD);
        put_byte(8'h5a);
        put_start(16'd0, 16'd0, 16'd0, 16'd0);
        put_op(OP_END);
        // Answer with a root name and an rdata length one above the reset limit.
        put_start(16'd0, 16'd1, 16'd0, 16'd0);
        put_byte(8'd0);
        put_field(32'h0001, 2);
        put_field(32'h0001, 2);
        put_field(32'hffffffff, 4);
        put_field(32'h0401, 2);
        // Compression pointer in place of a label length.
        put_start(16'd1, 16'd0, 16'd0, 16'd0);
        put_byte(8'hc0);
        // Full counts cut short by the end word.
        put_start(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        put_op(OP_END);
        send_queued();

        run_phase(16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 80);
        run_phase(16'hffff, 1'b0, 1'b0, 1'b0, 1'b1, 560);
        run_phase(16'd5, 1'b1, 1'b1, 1'b1, 1'b0, 150);
        run_phase(16'($urandom()), 1'b1, 1'b1, 1'b0, 1'b0, 60);
        run_phase(RDATA_LIMIT_RST, 1'b1, 1'b1, 1'b0, 1'b0, 50);
        drain();

        if (sb.mismatches == 0 && sb.pending_fields.size() == 0) begin
            $display("PASS dns_message_body_parser_core");
        end else begin
            $display("FAIL dns_message_body_parser_core");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/dmbp_pkg.sv
design/dmbp_parser.sv
design/dmbp_out_queue.sv
design/dns_message_body_parser_core.sv
bench/tb_top.sv
